// File: rtl/cmfs_pkg.sv
// ============================================================================
// cmfs_pkg
// Shared face codes and the pipeline control word for cube map face select.
// ============================================================================
`default_nettype none

package cmfs_pkg;

    localparam logic [2:0] FACE_RIGHT  = 3'd0;
    localparam logic [2:0] FACE_LEFT   = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    // Index of the two coordinate lanes
    localparam int LANE_U = 0;
    localparam int LANE_V = 1;

    // Travels with every transaction down the pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] face;
        logic       zero;
    } cmfs_ctl_t;

endpackage

`default_nettype wire

// File: rtl/cube_map_face_select_top.sv
// ============================================================================
// cube_map_face_select_top
// Picks the cube face of a direction vector and its face u/v coordinates.
// ============================================================================
//
//  channel   handshake          payload
//  --------  -----------------  -----------------------------------------
//  command   start / busy       dir_x, dir_y, dir_z
//  result    done (strobe)      face, u_coord, v_coord, zero_dir
//
//  One transaction enters per cycle; busy is always low. Each result passes the
//  face select register, the divider init registers and the restoring divider
//  that yields one fraction bit per stage for u and v side by side, then the
//  rounding register. Reset clears the valid bits of every stage; payload is
//  not reset. The receiver cannot stall, so the pipeline advances every cycle.
//
`default_nettype none

module cube_map_face_select_top #(
    parameter int COMP_WIDTH   = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COMP_WIDTH-1:0] dir_x,
    input  wire logic signed [COMP_WIDTH-1:0] dir_y,
    input  wire logic signed [COMP_WIDTH-1:0] dir_z,
    output logic                              done,
    output logic [2:0]                        face,
    output logic [UV_FRAC_BITS-1:0]           u_coord,
    output logic [UV_FRAC_BITS-1:0]           v_coord,
    output logic                              zero_dir
);
    import cmfs_pkg::*;

    localparam int W       = COMP_WIDTH;
    localparam int F       = UV_FRAC_BITS;
    localparam int LATENCY = UV_FRAC_BITS + 4;

    cmfs_ctl_t    sel_ctl;
    logic [W-1:0] sel_major, sel_minor_u, sel_minor_v;
    logic         sel_mir_u, sel_mir_v;

    cmfs_ctl_t    st_ctl   [F+1];
    logic [W-1:0] st_major [F+1];
    logic [W-1:0] st_rem_u [F+1];
    logic [W-1:0] st_rem_v [F+1];
    logic [F+1:0] st_quo_u [F+1];
    logic [F+1:0] st_quo_v [F+1];

    assign busy = 1'b0;

    cmfs_face_sel #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_face_sel (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start && !busy),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .ctl_out     (sel_ctl),
        .major_out   (sel_major),
        .minor_u_out (sel_minor_u),
        .minor_v_out (sel_minor_v),
        .mir_u_out   (sel_mir_u),
        .mir_v_out   (sel_mir_v)
    );

    cmfs_div_init #(
        .COMP_WIDTH   (COMP_WIDTH),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_div_init (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl_in     (sel_ctl),
        .major_in   (sel_major),
        .minor_u_in (sel_minor_u),
        .minor_v_in (sel_minor_v),
        .mir_u_in   (sel_mir_u),
        .mir_v_in   (sel_mir_v),
        .ctl_out    (st_ctl[0]),
        .major_out  (st_major[0]),
        .rem_u_out  (st_rem_u[0]),
        .rem_v_out  (st_rem_v[0]),
        .quo_u_out  (st_quo_u[0]),
        .quo_v_out  (st_quo_v[0])
    );

    for (genvar g = 0; g < F; g++)
    begin : g_step
        cmfs_div_step #(
            .COMP_WIDTH   (COMP_WIDTH),
            .UV_FRAC_BITS (UV_FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (st_ctl[g]),
            .major_in  (st_major[g]),
            .rem_u_in  (st_rem_u[g]),
            .rem_v_in  (st_rem_v[g]),
            .quo_u_in  (st_quo_u[g]),
            .quo_v_in  (st_quo_v[g]),
            .ctl_out   (st_ctl[g+1]),
            .major_out (st_major[g+1]),
            .rem_u_out (st_rem_u[g+1]),
            .rem_v_out (st_rem_v[g+1]),
            .quo_u_out (st_quo_u[g+1]),
            .quo_v_out (st_quo_v[g+1])
        );
    end

    cmfs_uv_round #(
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_uv_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (st_ctl[F]),
        .quo_u_in (st_quo_u[F]),
        .quo_v_in (st_quo_v[F]),
        .done     (done),
        .face     (face),
        .u_coord  (u_coord),
        .v_coord  (v_coord),
        .zero_dir (zero_dir)
    );

    // Every accepted transaction yields a done strobe at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after fixed latency");

    a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_dir) |->
            (face == FACE_RIGHT) && (u_coord == {1'b1, {(F-1){1'b0}}})
            && (v_coord == {1'b1, {(F-1){1'b0}}}))
        else $error("zero vector result not centered on the right face");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!st_ctl[F].valid) |=> !done)
        else $error("result strobe without a transaction in flight");

endmodule

`default_nettype wire

// File: rtl/cmfs_face_sel.sv
// ============================================================================
// cmfs_face_sel
// Magnitudes, major axis pick and per-face routing of the minor components.
// ============================================================================
`default_nettype none

module cmfs_face_sel #(
    parameter int COMP_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic signed [COMP_WIDTH-1:0] dir_x,
    input  wire logic signed [COMP_WIDTH-1:0] dir_y,
    input  wire logic signed [COMP_WIDTH-1:0] dir_z,
    output cmfs_pkg::cmfs_ctl_t               ctl_out,
    output logic [COMP_WIDTH-1:0]             major_out,
    output logic [COMP_WIDTH-1:0]             minor_u_out,
    output logic [COMP_WIDTH-1:0]             minor_v_out,
    output logic                              mir_u_out,
    output logic                              mir_v_out
);
    import cmfs_pkg::*;

    localparam int W = COMP_WIDTH;

    logic [W-1:0] xu, yu, zu;
    logic [W-1:0] ax, ay, az;
    logic         sel_x, sel_y, is_zero;
    cmfs_ctl_t    ctl_next;
    logic [W-1:0] major_next, minor_u_next, minor_v_next;
    logic         mir_u_next, mir_v_next;

    cmfs_ctl_t    ctl_reg;
    logic [W-1:0] major_reg, minor_u_reg, minor_v_reg;
    logic         mir_u_reg, mir_v_reg;

    always_comb
    begin
        xu = dir_x;
        yu = dir_y;
        zu = dir_z;
        // Unsigned magnitude; the most negative value maps to 2^(W-1) exactly
        ax = xu[W-1] ? (~xu + {{(W-1){1'b0}}, 1'b1}) : xu;
        ay = yu[W-1] ? (~yu + {{(W-1){1'b0}}, 1'b1}) : yu;
        az = zu[W-1] ? (~zu + {{(W-1){1'b0}}, 1'b1}) : zu;

        is_zero = (ax == '0) && (ay == '0) && (az == '0);
        sel_x   = (ax >= ay) && (ax >= az);
        sel_y   = (ay > ax) && (ay >= az);

        ctl_next.valid = in_valid;
        ctl_next.zero  = is_zero;
        if (sel_x)
        begin
            ctl_next.face = (xu[W-1] || is_zero) ? FACE_LEFT : FACE_RIGHT;
            major_next    = ax;
            minor_u_next  = zu;
            minor_v_next  = yu;
            mir_u_next    = xu[W-1];
            mir_v_next    = 1'b0;
        end
        else if (sel_y)
        begin
            ctl_next.face = yu[W-1] ? FACE_BOTTOM : FACE_TOP;
            major_next    = ay;
            minor_u_next  = xu;
            minor_v_next  = zu;
            mir_u_next    = 1'b0;
            mir_v_next    = yu[W-1];
        end
        else
        begin
            ctl_next.face = zu[W-1] ? FACE_BACK : FACE_FRONT;
            major_next    = az;
            minor_u_next  = xu;
            minor_v_next  = yu;
            mir_u_next    = ~zu[W-1];
            mir_v_next    = 1'b0;
        end
        // Zero vector reports the right face; the coordinates are overridden later
        if (is_zero)
        begin
            ctl_next.face = FACE_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg   <= major_next;
        minor_u_reg <= minor_u_next;
        minor_v_reg <= minor_v_next;
        mir_u_reg   <= mir_u_next;
        mir_v_reg   <= mir_v_next;
    end

    assign ctl_out     = ctl_reg;
    assign major_out   = major_reg;
    assign minor_u_out = minor_u_reg;
    assign minor_v_out = minor_v_reg;
    assign mir_u_out   = mir_u_reg;
    assign mir_v_out   = mir_v_reg;

endmodule

`default_nettype wire

// File: rtl/cmfs_div_init.sv
// ============================================================================
// cmfs_div_init
// Builds the numerators major +/- minor and resolves the integer quotient bits.
// ============================================================================
`default_nettype none

module cmfs_div_init #(
    parameter int COMP_WIDTH   = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmfs_pkg::cmfs_ctl_t     ctl_in,
    input  wire logic [COMP_WIDTH-1:0]   major_in,
    input  wire logic [COMP_WIDTH-1:0]   minor_u_in,
    input  wire logic [COMP_WIDTH-1:0]   minor_v_in,
    input  wire logic                    mir_u_in,
    input  wire logic                    mir_v_in,
    output cmfs_pkg::cmfs_ctl_t          ctl_out,
    output logic [COMP_WIDTH-1:0]        major_out,
    output logic [COMP_WIDTH-1:0]        rem_u_out,
    output logic [COMP_WIDTH-1:0]        rem_v_out,
    output logic [UV_FRAC_BITS+1:0]      quo_u_out,
    output logic [UV_FRAC_BITS+1:0]      quo_v_out
);
    import cmfs_pkg::*;

    localparam int W = COMP_WIDTH;
    localparam int F = UV_FRAC_BITS;

    logic [W-1:0]        minor  [2];
    logic                mir    [2];
    logic signed [W+1:0] mext;
    logic signed [W+1:0] cext   [2];
    logic signed [W+1:0] sum    [2];
    logic [W:0]          num_next [2];

    cmfs_ctl_t           ctl_a_reg;
    logic [W-1:0]        major_a_reg;
    logic [W:0]          num_reg [2];

    logic [W:0]          two_m, one_m;
    logic [W:0]          diff   [2];
    logic [W-1:0]        rem_next [2];
    logic [1:0]          qi     [2];

    cmfs_ctl_t           ctl_b_reg;
    logic [W-1:0]        major_b_reg;
    logic [W-1:0]        rem_reg [2];
    logic [F+1:0]        quo_reg [2];

    // Numerator in [0, 2*major]
    always_comb
    begin
        minor[LANE_U] = minor_u_in;
        minor[LANE_V] = minor_v_in;
        mir[LANE_U]   = mir_u_in;
        mir[LANE_V]   = mir_v_in;
        mext = $signed({2'b00, major_in});
        for (int i = 0; i < 2; i++)
        begin
            cext[i]     = $signed({{2{minor[i][W-1]}}, minor[i]});
            sum[i]      = mir[i] ? (mext - cext[i]) : (mext + cext[i]);
            num_next[i] = sum[i][W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        major_a_reg <= major_in;
        num_reg     <= num_next;
    end

    // Integer part of num/major is 0, 1 or 2; remainder leaves below major
    always_comb
    begin
        two_m = {major_a_reg, 1'b0};
        one_m = {1'b0, major_a_reg};
        for (int i = 0; i < 2; i++)
        begin
            diff[i] = num_reg[i] - one_m;
            if (num_reg[i] >= two_m)
            begin
                qi[i]       = 2'd2;
                rem_next[i] = '0;
            end
            else if (num_reg[i] >= one_m)
            begin
                qi[i]       = 2'd1;
                rem_next[i] = diff[i][W-1:0];
            end
            else
            begin
                qi[i]       = 2'd0;
                rem_next[i] = num_reg[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        major_b_reg <= major_a_reg;
        rem_reg     <= rem_next;
        for (int i = 0; i < 2; i++)
        begin
            quo_reg[i] <= {{F{1'b0}}, qi[i]};
        end
    end

    assign ctl_out   = ctl_b_reg;
    assign major_out = major_b_reg;
    assign rem_u_out = rem_reg[LANE_U];
    assign rem_v_out = rem_reg[LANE_V];
    assign quo_u_out = quo_reg[LANE_U];
    assign quo_v_out = quo_reg[LANE_V];

endmodule

`default_nettype wire

// File: rtl/cmfs_div_step.sv
// ============================================================================
// cmfs_div_step
// One restoring division stage: one fraction bit for both u and v.
// ============================================================================
`default_nettype none

module cmfs_div_step #(
    parameter int COMP_WIDTH   = 16,
    parameter int UV_FRAC_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmfs_pkg::cmfs_ctl_t     ctl_in,
    input  wire logic [COMP_WIDTH-1:0]   major_in,
    input  wire logic [COMP_WIDTH-1:0]   rem_u_in,
    input  wire logic [COMP_WIDTH-1:0]   rem_v_in,
    input  wire logic [UV_FRAC_BITS+1:0] quo_u_in,
    input  wire logic [UV_FRAC_BITS+1:0] quo_v_in,
    output cmfs_pkg::cmfs_ctl_t          ctl_out,
    output logic [COMP_WIDTH-1:0]        major_out,
    output logic [COMP_WIDTH-1:0]        rem_u_out,
    output logic [COMP_WIDTH-1:0]        rem_v_out,
    output logic [UV_FRAC_BITS+1:0]      quo_u_out,
    output logic [UV_FRAC_BITS+1:0]      quo_v_out
);
    import cmfs_pkg::*;

    localparam int W = COMP_WIDTH;
    localparam int F = UV_FRAC_BITS;

    logic [W-1:0] rem_in   [2];
    logic [F+1:0] quo_in   [2];
    logic [W:0]   dbl      [2];
    logic [W:0]   sub      [2];
    logic         bit_q    [2];
    logic [W-1:0] rem_next [2];
    logic [F+1:0] quo_next [2];

    cmfs_ctl_t    ctl_reg;
    logic [W-1:0] major_reg;
    logic [W-1:0] rem_reg [2];
    logic [F+1:0] quo_reg [2];

    always_comb
    begin
        rem_in[LANE_U] = rem_u_in;
        rem_in[LANE_V] = rem_v_in;
        quo_in[LANE_U] = quo_u_in;
        quo_in[LANE_V] = quo_v_in;
        for (int i = 0; i < 2; i++)
        begin
            dbl[i]   = {rem_in[i], 1'b0};
            sub[i]   = dbl[i] - {1'b0, major_in};
            bit_q[i] = (dbl[i] >= {1'b0, major_in});
            // Either branch stays below major, so W bits hold it
            rem_next[i] = bit_q[i] ? sub[i][W-1:0] : dbl[i][W-1:0];
            quo_next[i] = {quo_in[i][F:0], bit_q[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= major_in;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign ctl_out   = ctl_reg;
    assign major_out = major_reg;
    assign rem_u_out = rem_reg[LANE_U];
    assign rem_v_out = rem_reg[LANE_V];
    assign quo_u_out = quo_reg[LANE_U];
    assign quo_v_out = quo_reg[LANE_V];

endmodule

`default_nettype wire

// File: rtl/cmfs_uv_round.sv
// ============================================================================
// cmfs_uv_round
// Halves the quotient with round-half-up, saturates, applies the zero vector.
// ============================================================================
`default_nettype none

module cmfs_uv_round #(
    parameter int UV_FRAC_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmfs_pkg::cmfs_ctl_t     ctl_in,
    input  wire logic [UV_FRAC_BITS+1:0] quo_u_in,
    input  wire logic [UV_FRAC_BITS+1:0] quo_v_in,
    output logic                         done,
    output logic [2:0]                   face,
    output logic [UV_FRAC_BITS-1:0]      u_coord,
    output logic [UV_FRAC_BITS-1:0]      v_coord,
    output logic                         zero_dir
);
    import cmfs_pkg::*;

    localparam int F = UV_FRAC_BITS;

    logic [F+1:0] quo_in     [2];
    logic [F+2:0] rnd        [2];
    logic [F+1:0] half       [2];
    logic [F-1:0] coord_next [2];

    logic         done_reg;
    logic [2:0]   face_reg;
    logic         zero_reg;
    logic [F-1:0] coord_reg  [2];

    // quo = floor(num * 2^F / major); coordinate = floor((quo + 1) / 2)
    always_comb
    begin
        quo_in[LANE_U] = quo_u_in;
        quo_in[LANE_V] = quo_v_in;
        for (int i = 0; i < 2; i++)
        begin
            rnd[i]  = {1'b0, quo_in[i]} + {{(F+2){1'b0}}, 1'b1};
            half[i] = rnd[i][F+2:1];
            if (ctl_in.zero)
            begin
                coord_next[i] = {1'b1, {(F-1){1'b0}}};
            end
            else if (half[i][F+1:F] != 2'b00)
            begin
                coord_next[i] = '1;
            end
            else
            begin
                coord_next[i] = half[i][F-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        face_reg  <= ctl_in.face;
        zero_reg  <= ctl_in.zero;
        coord_reg <= coord_next;
    end

    assign done     = done_reg;
    assign face     = face_reg;
    assign zero_dir = zero_reg;
    assign u_coord  = coord_reg[LANE_U];
    assign v_coord  = coord_reg[LANE_V];

endmodule

`default_nettype wire

// File: sim/tb_cube_map_face_select_top.sv
// ----------------------------------------------------------------------------
// tb_cube_map_face_select_top
// Self-checking bench for cube map face select: directed corner vectors, then
// constrained-random directions under varying start gaps. Each transaction is
// predicted in-bench and every done strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb_cube_map_face_select_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cmfs_pkg::*;

    localparam int COMP_WIDTH   = 16;
    localparam int UV_FRAC_BITS = 16;
    localparam int LATENCY      = UV_FRAC_BITS + 4;
    localparam int RANDOM_ITEMS = 560;   // per idling phase

    typedef struct {
        logic signed [COMP_WIDTH-1:0] x;
        logic signed [COMP_WIDTH-1:0] y;
        logic signed [COMP_WIDTH-1:0] z;
    } dir_t;

    typedef struct packed {
        logic [2:0]              face;
        logic [UV_FRAC_BITS-1:0] u;
        logic [UV_FRAC_BITS-1:0] v;
        logic                    zero;
    } face_uv_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic signed [COMP_WIDTH-1:0]   dir_x = '0;
    logic signed [COMP_WIDTH-1:0]   dir_y = '0;
    logic signed [COMP_WIDTH-1:0]   dir_z = '0;
    logic                           busy;
    logic                           done;
    logic [2:0]                     face;
    logic [UV_FRAC_BITS-1:0]        u_coord;
    logic [UV_FRAC_BITS-1:0]        v_coord;
    logic                           zero_dir;

    dir_t     dir_queue[$];
    face_uv_t face_uv_queue[$];
    int       dirs_queued   = 0;
    int       dirs_accepted = 0;
    int       idle_pct      = 25;
    int       error_count   = 0;

    cube_map_face_select_top #(
        .COMP_WIDTH   (COMP_WIDTH),
        .UV_FRAC_BITS (UV_FRAC_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .done     (done),
        .face     (face),
        .u_coord  (u_coord),
        .v_coord  (v_coord),
        .zero_dir (zero_dir)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("Regression FAIL");
        $finish;
    end

    // (major + s*minor) / (2*major) in Q0.UV_FRAC_BITS, round half up, clamp
    function automatic logic [UV_FRAC_BITS-1:0] uv_ratio(longint minor, longint major,
                                                         bit mirror);
        longint num;
        longint q;
        num = mirror ? major - minor : major + minor;
        q = ((num <<< UV_FRAC_BITS) + major) / (2 * major);
        if (q > (longint'(1) <<< UV_FRAC_BITS) - 1)
            q = (longint'(1) <<< UV_FRAC_BITS) - 1;
        return q[UV_FRAC_BITS-1:0];
    endfunction

    function automatic face_uv_t predict_face_uv(dir_t d);
        longint   x, y, z, ax, ay, az;
        face_uv_t r;
        x  = d.x;
        y  = d.y;
        z  = d.z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r.zero = 1'b0;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            r.face = FACE_RIGHT;
            r.u    = {1'b1, {(UV_FRAC_BITS-1){1'b0}}};
            r.v    = {1'b1, {(UV_FRAC_BITS-1){1'b0}}};
            r.zero = 1'b1;
        end
        else if (ax >= ay && ax >= az)
        begin
            r.face = (x > 0) ? FACE_RIGHT : FACE_LEFT;
            r.u    = uv_ratio(z, ax, x <= 0);
            r.v    = uv_ratio(y, ax, 1'b0);
        end
        else if (ay > ax && ay >= az)
        begin
            r.face = (y > 0) ? FACE_TOP : FACE_BOTTOM;
            r.u    = uv_ratio(x, ay, 1'b0);
            r.v    = uv_ratio(z, ay, y <= 0);
        end
        else
        begin
            r.face = (z > 0) ? FACE_FRONT : FACE_BACK;
            r.u    = uv_ratio(x, az, z > 0);
            r.v    = uv_ratio(y, az, 1'b0);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < 40)
            $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic queue_dir(int x, int y, int z);
        dir_t d;
        d.x = COMP_WIDTH'(x);
        d.y = COMP_WIDTH'(y);
        d.z = COMP_WIDTH'(z);
        dir_queue.push_back(d);
        dirs_queued++;
    endtask

    // Component of magnitude near base, random sign; clips +32768
    function automatic int near_comp(int base);
        int m;
        case ($urandom_range(3, 0))
            0:       m = base;
            1:       m = base - 1;
            2:       m = $urandom_range(base, 0);
            default: m = base;
        endcase
        if ($urandom_range(1, 0))
            return -m;
        return (m > 32767) ? 32767 : m;
    endfunction

    function automatic int corner_comp();
        case ($urandom_range(6, 0))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32767;
            default: return 32766;
        endcase
    endfunction

    task automatic queue_random_dir();
        int base;
        int lim;
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
                queue_dir($signed(16'($urandom)), $signed(16'($urandom)),
                          $signed(16'($urandom)));
            4:
                queue_dir($urandom_range(6, 0) - 3, $urandom_range(6, 0) - 3,
                          $urandom_range(6, 0) - 3);
            5, 6:
            begin
                base = ($urandom_range(3, 0) == 0) ? $urandom_range(8, 1)
                                                   : $urandom_range(32768, 1);
                queue_dir(near_comp(base), near_comp(base), near_comp(base));
            end
            7:
                queue_dir(corner_comp(), corner_comp(), corner_comp());
            8:
            begin
                // components are bounded by 255 or by 32767, chosen at random
                lim = $urandom_range(1, 0) ? 255 : 32767;
                queue_dir($urandom_range(2 * lim, 0) - lim, $urandom_range(2 * lim, 0) - lim,
                          $urandom_range(2 * lim, 0) - lim);
            end
            default:
            begin
                if ($urandom_range(1, 0))
                    queue_dir(0, 0, 0);
                else
                    case ($urandom_range(2, 0))
                        0:       queue_dir(corner_comp(), 0, 0);
                        1:       queue_dir(0, corner_comp(), 0);
                        default: queue_dir(0, 0, corner_comp());
                    endcase
            end
        endcase
    endtask

    task automatic wait_accepted();
        while (dirs_accepted != dirs_queued)
            @(posedge clk);
    endtask

    // Driver: a transaction moves on the edge where start is high and busy low
    always @(posedge clk)
    begin
        dir_t d;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                d.x = dir_x;
                d.y = dir_y;
                d.z = dir_z;
                face_uv_queue.push_back(predict_face_uv(d));
                dirs_accepted++;
            end
            if (!start || !busy)
            begin
                if (dir_queue.size() > 0 && $urandom_range(99, 0) >= idle_pct)
                begin
                    d = dir_queue.pop_front();
                    start <= 1'b1;
                    dir_x <= d.x;
                    dir_y <= d.y;
                    dir_z <= d.z;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: done is a one-cycle strobe, no backpressure
    always @(posedge clk)
    begin
        face_uv_t e;
        if (rst_n && done)
        begin
            if (face_uv_queue.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                e = face_uv_queue.pop_front();
                if (face !== e.face)
                    report_mismatch($sformatf("face got %0d exp %0d", face, e.face));
                if (u_coord !== e.u)
                    report_mismatch($sformatf("u_coord got %0d exp %0d", u_coord, e.u));
                if (v_coord !== e.v)
                    report_mismatch($sformatf("v_coord got %0d exp %0d", v_coord, e.v));
                if (zero_dir !== e.zero)
                    report_mismatch($sformatf("zero_dir got %0b exp %0b", zero_dir, e.zero));
            end
        end
    end

    initial
    begin
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        queue_dir(0, 0, 0);
        queue_dir(1, 0, 0);
        queue_dir(-1, 0, 0);
        queue_dir(0, 1, 0);
        queue_dir(0, -1, 0);
        queue_dir(0, 0, 1);
        queue_dir(0, 0, -1);
        queue_dir(32767, -32768, 0);          // y wins by one count
        queue_dir(-32768, 32767, 32767);
        queue_dir(-32768, -32768, -32768);    // full tie, x wins
        queue_dir(0, -32768, -32768);         // y/z tie, y wins
        queue_dir(0, 32767, -32768);
        queue_dir(32767, 32767, 32767);
        queue_dir(1000, -1000, 1000);
        queue_dir(5, 0, 5);                   // u saturates on right face
        queue_dir(-7, 0, -7);                 // mirrored saturation on left face
        queue_dir(0, -9, 9);                  // mirrored v hits zero on bottom face
        queue_dir(-3, 0, 3);                  // x wins the x/z tie; mirrored u hits zero on left face
        queue_dir(3, 1, 0);                   // v of two thirds rounds up
        queue_dir(32767, 1, -1);
        queue_dir(-32768, 32767, -32767);
        queue_dir(21845, -10923, 32767);
        queue_dir(-1, 1, -1);
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_random_dir();
        wait_accepted();

        idle_pct = 61;
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_random_dir();
        wait_accepted();

        idle_pct = 0;
        for (k = 0; k < RANDOM_ITEMS; k++)
            queue_random_dir();
        wait_accepted();

        while (face_uv_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 12) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
